/* sv/lrasm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrasm_pkg: shared types and constants
// Node record, unit controls, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package lrasm_pkg;

  localparam int LEAF_COUNT = 1024;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_ASSIGN = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic        ADDR_ELEMENT_COUNT  = 1'b0;
  localparam logic [10:0] ELEMENT_COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic        pending;
    logic        asg_valid;
    logic [63:0] asg_value;
    logic [63:0] add;
    logic [63:0] sum;
    logic [63:0] min;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    UOP_PASS,
    UOP_APPLY,
    UOP_CLEAR,
    UOP_REBUILD
  } uop_t;

  typedef struct packed {
    uop_t        uop;
    logic        has_asg;
    logic [63:0] asg_v;
    logic [63:0] add_v;
    logic [5:0]  sh;
  } unit_ctrl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_PAR,
    ST_PUSH_C0,
    ST_PUSH_C1,
    ST_PUSH_CLR,
    ST_RNG,
    ST_RNG_LO,
    ST_RNG_CHK,
    ST_RNG_HI,
    ST_REB,
    ST_REB_A,
    ST_REB_B,
    ST_REB_K,
    ST_RESP
  } state_t;

  function automatic logic signed_less(input logic [63:0] a, input logic [63:0] b);
    signed_less = $signed(a) < $signed(b);
  endfunction

endpackage
`default_nettype wire

/* sv/lrasm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrasm_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrasm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/lrasm_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrasm_unit: shared node update unit
// Applies a tag to a node, clears a node's tags, or rebuilds it from children.
// ----------------------------------------------------------------------------
module lrasm_unit
  import lrasm_pkg::*;
(
  input  wire unit_ctrl_t ctrl,
  input  wire node_t      node_i,
  input  wire node_t      c0_i,
  input  wire node_t      c1_i,
  output node_t           node_o
);

  always_comb begin
    node_o = node_i;
    case (ctrl.uop)
      UOP_APPLY: begin
        if (ctrl.has_asg) begin
          node_o.sum       = (ctrl.asg_v << ctrl.sh) + (ctrl.add_v << ctrl.sh);
          node_o.min       = ctrl.asg_v + ctrl.add_v;
          node_o.asg_valid = 1'b1;
          node_o.asg_value = ctrl.asg_v;
          node_o.add       = ctrl.add_v;
        end else begin
          node_o.sum = node_i.sum + (ctrl.add_v << ctrl.sh);
          node_o.min = node_i.min + ctrl.add_v;
          node_o.add = node_i.add + ctrl.add_v;
        end
        node_o.pending = 1'b1;
      end
      UOP_CLEAR: begin
        node_o.pending   = 1'b0;
        node_o.asg_valid = 1'b0;
        node_o.asg_value = '0;
        node_o.add       = '0;
      end
      UOP_REBUILD: begin
        node_o.sum = c0_i.sum + c1_i.sum;
        node_o.min = signed_less(c1_i.min, c0_i.min) ? c1_i.min : c0_i.min;
      end
      default: begin
        node_o = node_i;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/lazy_range_add_assign_sum_min.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lazy_range_add_assign_sum_min: lazy segment tree, range add/assign/query
// Sequencer around one node memory and one shared node update unit.
// ----------------------------------------------------------------------------
// After reset every node of the node memory is cleared; no item is
// taken meanwhile, configuration writes are.
// A bad range or unused code goes straight to the response state to offer its result.
// A valid item offers its result after a tree walk that is bounded by the
// single read port of the node memory; one item is handled at a time.
// Reset is synchronous and active low; element_count resets to 1024.
module lazy_range_add_assign_sum_min
  import lrasm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [9:0]  in_range_left,
  input  wire logic [10:0] in_range_right,
  input  wire logic [31:0] in_operand_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [63:0]      out_range_sum,
  output logic [63:0]      out_range_min,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LW = $clog2(LEAF_COUNT);
  localparam int AW = LW + 1;
  localparam int NW = LW + 2;
  localparam int SW = $clog2(LW + 2);
  localparam int DEPTH = 2 * LEAF_COUNT;

  state_t          state_r, state_nxt;
  logic [10:0]     cnt_r;
  func_t           func_r, func_nxt;
  logic [NW-1:0]   l_r, l_nxt, r_r, r_nxt, leaf_r, leaf_nxt;
  logic [NW-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [63:0]     val_r, val_nxt;
  logic            side_r, side_nxt;
  logic [SW-1:0]   s_r, s_nxt, lv_r, lv_nxt;
  node_t           par_r, par_nxt, c0_r, c0_nxt, c1_r, c1_nxt;
  logic [63:0]     acc_sum_r, acc_sum_nxt, acc_min_r, acc_min_nxt;
  logic            have_min_r, have_min_nxt;
  logic            status_r, status_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_status_r;
  logic [63:0]     out_sum_r, out_min_r;
  logic            out_load;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  node_t           ram_wdata, ram_rdata;
  unit_ctrl_t      uctrl;
  node_t           unode, unit_out;

  logic [NW-1:0]   base, node_k, r_m1, sel;
  logic [AW-1:0]   k_a, k2_a, k2p_a;
  logic            aligned, bad, is_push, upd_asg;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == ADDR_ELEMENT_COUNT) ? {21'd0, cnt_r} : 32'd0;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_range_sum = out_sum_r;
  assign out_range_min = out_min_r;

  assign r_m1    = r_r - 1'b1;
  assign is_push = (state_r == ST_PUSH_RD) || (state_r == ST_PUSH_PAR) ||
                   (state_r == ST_PUSH_C0) || (state_r == ST_PUSH_C1) ||
                   (state_r == ST_PUSH_CLR);
  assign base    = is_push ? leaf_r : (side_r ? r_m1 : l_r);
  assign node_k  = base >> s_r;
  assign k_a     = node_k[AW-1:0];
  assign k2_a    = {node_k[AW-2:0], 1'b0};
  assign k2p_a   = {node_k[AW-2:0], 1'b1};
  assign sel     = side_r ? r_r : l_r;
  assign aligned = ((sel >> s_r) << s_r) == sel;
  assign upd_asg = (func_r == FUNC_ASSIGN);
  assign bad     = (in_range_left >= in_range_right[9:0] && in_range_right[10] == 1'b0) ||
                   (in_range_right > cnt_r) ||
                   (32'(in_range_right) > 32'(LEAF_COUNT));
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  lrasm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lrasm_unit u_unit (
    .ctrl   (uctrl),
    .node_i (unode),
    .c0_i   (c0_r),
    .c1_i   (c1_r),
    .node_o (unit_out)
  );

  // Next state and datapath registers.
  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    l_nxt        = l_r;
    r_nxt        = r_r;
    leaf_nxt     = leaf_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    val_nxt      = val_r;
    side_nxt     = side_r;
    s_nxt        = s_r;
    lv_nxt       = lv_r;
    par_nxt      = par_r;
    c0_nxt       = c0_r;
    c1_nxt       = c1_r;
    acc_sum_nxt  = acc_sum_r;
    acc_min_nxt  = acc_min_r;
    have_min_nxt = have_min_r;
    status_nxt   = status_r;
    clr_nxt      = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt     = func_t'(in_func);
          val_nxt      = {{32{in_operand_value[31]}}, in_operand_value};
          l_nxt        = NW'(in_range_left) + NW'(LEAF_COUNT);
          r_nxt        = NW'(in_range_right) + NW'(LEAF_COUNT);
          leaf_nxt     = NW'(in_range_left) + NW'(LEAF_COUNT);
          side_nxt     = 1'b0;
          s_nxt        = SW'(LW);
          acc_sum_nxt  = '0;
          acc_min_nxt  = '0;
          have_min_nxt = 1'b0;
          status_nxt   = 1'b0;
          if (func_t'(in_func) == FUNC_NONE) begin
            state_nxt = ST_RESP;
          end else if (bad) begin
            status_nxt = 1'b1;
            state_nxt  = ST_RESP;
          end else begin
            state_nxt = ST_PUSH_RD;
          end
        end
      end
      ST_PUSH_RD: begin
        if (s_r == '0) begin
          if (!side_r) begin
            side_nxt = 1'b1;
            leaf_nxt = r_m1;
            s_nxt    = SW'(LW);
          end else begin
            lo_nxt    = l_r;
            hi_nxt    = r_r;
            lv_nxt    = '0;
            state_nxt = ST_RNG;
          end
        end else begin
          state_nxt = ST_PUSH_PAR;
        end
      end
      ST_PUSH_PAR: begin
        par_nxt = ram_rdata;
        if (!ram_rdata.pending) begin
          s_nxt     = s_r - 1'b1;
          state_nxt = ST_PUSH_RD;
        end else begin
          state_nxt = ST_PUSH_C0;
        end
      end
      ST_PUSH_C0:  state_nxt = ST_PUSH_C1;
      ST_PUSH_C1:  state_nxt = ST_PUSH_CLR;
      ST_PUSH_CLR: begin
        s_nxt     = s_r - 1'b1;
        state_nxt = ST_PUSH_RD;
      end
      ST_RNG: begin
        if (lo_r < hi_r) begin
          state_nxt = lo_r[0] ? ST_RNG_LO : ST_RNG_CHK;
        end else if (func_r == FUNC_QUERY) begin
          state_nxt = ST_RESP;
        end else begin
          side_nxt  = 1'b0;
          s_nxt     = SW'(1);
          state_nxt = ST_REB;
        end
      end
      ST_RNG_LO, ST_RNG_HI: begin
        if (func_r == FUNC_QUERY) begin
          acc_sum_nxt = acc_sum_r + ram_rdata.sum;
          if (!have_min_r || signed_less(ram_rdata.min, acc_min_r)) begin
            acc_min_nxt = ram_rdata.min;
          end
          have_min_nxt = 1'b1;
        end
        if (state_r == ST_RNG_LO) begin
          lo_nxt    = lo_r + 1'b1;
          state_nxt = ST_RNG_CHK;
        end else begin
          lo_nxt    = lo_r >> 1;
          hi_nxt    = hi_r >> 1;
          lv_nxt    = lv_r + 1'b1;
          state_nxt = ST_RNG;
        end
      end
      ST_RNG_CHK: begin
        if (hi_r[0]) begin
          hi_nxt    = hi_r - 1'b1;
          state_nxt = ST_RNG_HI;
        end else begin
          lo_nxt    = lo_r >> 1;
          hi_nxt    = hi_r >> 1;
          lv_nxt    = lv_r + 1'b1;
          state_nxt = ST_RNG;
        end
      end
      ST_REB: begin
        if (s_r > SW'(LW)) begin
          state_nxt = ST_RESP;
        end else if (!aligned) begin
          state_nxt = ST_REB_A;
        end else begin
          side_nxt = !side_r;
          if (side_r) begin
            s_nxt = s_r + 1'b1;
          end
        end
      end
      ST_REB_A: begin
        c0_nxt    = ram_rdata;
        state_nxt = ST_REB_B;
      end
      ST_REB_B: begin
        c1_nxt    = ram_rdata;
        state_nxt = ST_REB_K;
      end
      ST_REB_K: begin
        side_nxt = !side_r;
        if (side_r) begin
          s_nxt = s_r + 1'b1;
        end
        state_nxt = ST_REB;
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory and unit controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_a;
    ram_raddr = k_a;
    uctrl     = '{uop: UOP_PASS, has_asg: 1'b0, asg_v: 64'd0, add_v: 64'd0, sh: 6'd0};
    unode     = ram_rdata;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        uctrl.uop = UOP_CLEAR;
        unode     = '0;
      end
      ST_PUSH_PAR: ram_raddr = k2_a;
      ST_PUSH_C0, ST_PUSH_C1: begin
        ram_we        = 1'b1;
        ram_waddr     = (state_r == ST_PUSH_C0) ? k2_a : k2p_a;
        ram_raddr     = k2p_a;
        uctrl.uop     = UOP_APPLY;
        uctrl.has_asg = par_r.asg_valid;
        uctrl.asg_v   = par_r.asg_value;
        uctrl.add_v   = par_r.add;
        uctrl.sh      = 6'(s_r - 1'b1);
      end
      ST_PUSH_CLR: begin
        ram_we    = 1'b1;
        uctrl.uop = UOP_CLEAR;
        unode     = par_r;
      end
      ST_RNG: ram_raddr = lo_r[AW-1:0];
      ST_RNG_CHK: ram_raddr = AW'(hi_r - 1'b1);
      ST_RNG_LO, ST_RNG_HI: begin
        ram_we        = (func_r != FUNC_QUERY);
        ram_waddr     = (state_r == ST_RNG_LO) ? lo_r[AW-1:0] : hi_r[AW-1:0];
        uctrl.uop     = UOP_APPLY;
        uctrl.has_asg = upd_asg;
        uctrl.asg_v   = val_r;
        uctrl.add_v   = upd_asg ? 64'd0 : val_r;
        uctrl.sh      = 6'(lv_r);
      end
      ST_REB:   ram_raddr = k2_a;
      ST_REB_A: ram_raddr = k2p_a;
      ST_REB_B: ram_raddr = k_a;
      ST_REB_K: begin
        ram_we    = 1'b1;
        uctrl.uop = UOP_REBUILD;
      end
      default: ram_we = 1'b0;
    endcase
    ram_wdata = unit_out;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= ELEMENT_COUNT_RESET;
      out_valid_r <= 1'b0;
      func_r      <= FUNC_NONE;
      side_r      <= 1'b0;
      s_r         <= '0;
      lv_r        <= '0;
      have_min_r  <= 1'b0;
      status_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      side_r      <= side_nxt;
      s_r         <= s_nxt;
      lv_r        <= lv_nxt;
      have_min_r  <= have_min_nxt;
      status_r    <= status_nxt;
      if (psel && penable && pwrite && pready && paddr[2] == ADDR_ELEMENT_COUNT) begin
        cnt_r <= pwdata[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    leaf_r    <= leaf_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    val_r     <= val_nxt;
    par_r     <= par_nxt;
    c0_r      <= c0_nxt;
    c1_r      <= c1_nxt;
    acc_sum_r <= acc_sum_nxt;
    acc_min_r <= acc_min_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_sum_r    <= acc_sum_r;
      out_min_r    <= acc_min_r;
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("node memory written while idle");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_sum_r == 64'd0 && out_min_r == 64'd0))
    else $error("bad-range result carries nonzero data");

  a_rng_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RNG_LO) |-> (lo_r < hi_r))
    else $error("range walk visits a node outside the range");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for lazy_range_add_assign_sum_min
// Range add, assign and sum/minimum queries are sent with random gaps and
// output stalls; a flat array model predicts every result, which is compared
// field by field in transfer order. The element count is changed between
// phases through the APB-style port.
// ----------------------------------------------------------------------------
module testbench;
  import lrasm_pkg::*;

  localparam int LEAVES = 1024;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  typedef struct {
    logic        status;
    logic [63:0] sum;
    logic [63:0] min;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic [9:0]  in_range_left = '0;
  logic [10:0] in_range_right = '0;
  logic [31:0] in_operand_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        out_status;
  logic [63:0] out_range_sum;
  logic [63:0] out_range_min;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [63:0] elem_value [LEAVES];
  logic [10:0] active_count;
  outcome_t    pending_results [$];
  int          mismatch_count = 0;
  int          out_wait = 0;
  longint      cycle_count = 0;

  lazy_range_add_assign_sum_min u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic outcome_t predict_range_op(logic [1:0] f, logic [9:0] lft,
                                                logic [10:0] rgt, logic [31:0] v);
    outcome_t    o;
    logic [63:0] sv;
    o.status = 1'b0;
    o.sum = '0;
    o.min = '0;
    sv = {{32{v[31]}}, v};
    if (f == FUNC_NONE) return o;
    if (lft >= rgt || rgt > active_count || rgt > LEAVES) begin
      o.status = 1'b1;
      return o;
    end
    for (int i = lft; i < rgt; i++) begin
      case (f)
        FUNC_ADD: elem_value[i] = elem_value[i] + sv;
        FUNC_ASSIGN: elem_value[i] = sv;
        default: begin
          o.sum = o.sum + elem_value[i];
          if (i == lft || $signed(elem_value[i]) < $signed(o.min)) o.min = elem_value[i];
        end
      endcase
    end
    return o;
  endfunction

  // Checks every result transfer against the oldest prediction.
  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer");
      end else begin
        exp_o = pending_results.pop_front();
        if (exp_o.status !== out_status || exp_o.sum !== out_range_sum ||
            exp_o.min !== out_range_min) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %0d %h %h, got %0d %h %h", exp_o.status,
                     exp_o.sum, exp_o.min, out_status, out_range_sum, out_range_min);
        end
      end
    end
  end

  // Each result waits a freshly drawn number of cycles before it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_wait = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_wait = $urandom_range(0, 12);
      out_stall <= (out_wait != 0);
    end else if (out_valid && out_wait != 0) begin
      out_wait = out_wait - 1;
      out_stall <= (out_wait != 0);
    end else if (out_wait == 0) begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic [1:0] f, logic [9:0] lft, logic [10:0] rgt,
                           logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_range_left <= lft;
    in_range_right <= rgt;
    in_operand_value <= v;
    pending_results.push_back(predict_range_op(f, lft, rgt, v));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_element_count(logic [10:0] cnt);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(ADDR_ELEMENT_COUNT) << 2;
    pwdata <= 32'(cnt);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_count = cnt;
  endtask

  task automatic random_item(int span);
    logic [10:0] a, b;
    int r;
    r = $urandom_range(0, 19);
    a = 11'($urandom_range(0, span - 1));
    b = 11'($urandom_range(a + 1, span));
    if (r == 0) b = a;
    if (r == 1) b = 11'($urandom_range(0, LEAVES));
    send_item(r == 2 ? FUNC_NONE : 2'($urandom_range(0, 2)), a[9:0], b,
              ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 20)) - 10 : $urandom);
  endtask

  task automatic test_directed();
    send_item(FUNC_QUERY, 10'd0, 11'd1024, '0);
    send_item(FUNC_ASSIGN, 10'd0, 11'd1024, 32'h7fffffff);
    send_item(FUNC_ADD, 10'd1, 11'd1023, 32'h7fffffff);
    send_item(FUNC_QUERY, 10'd0, 11'd1024, '0);
    send_item(FUNC_ASSIGN, 10'd1023, 11'd1024, 32'h80000000);
    send_item(FUNC_QUERY, 10'd1000, 11'd1024, '0);
    send_item(FUNC_ADD, 10'd5, 11'd5, 32'd3);
    send_item(FUNC_QUERY, 10'd9, 11'd3, '0);
    send_item(FUNC_QUERY, 10'd0, 11'd0, '0);
    send_item(FUNC_NONE, 10'd0, 11'd10, 32'hffffffff);
    send_item(FUNC_QUERY, 10'd1023, 11'd1024, '0);
    send_item(FUNC_ADD, 10'd0, 11'd1024, 32'h80000000);
    send_item(FUNC_QUERY, 10'd512, 11'd513, '0);
    send_item(FUNC_QUERY, 10'd0, 11'd1024, 32'hffffffff);
    send_item(FUNC_QUERY, 10'd3, 11'd2047, '0);
    drain_results();
  endtask

  task automatic test_wraparound();
    // Large repeated adds drive element values and sums far past 32 bits.
    send_item(FUNC_ASSIGN, 10'd0, 11'd1024, 32'h7fffffff);
    for (int i = 0; i < 30; i++) send_item(FUNC_ADD, 10'd0, 11'd1024, 32'h7fffffff);
    send_item(FUNC_QUERY, 10'd0, 11'd1024, '0);
    send_item(FUNC_QUERY, 10'd17, 11'd300, '0);
    drain_results();
  endtask

  task automatic test_count_limits();
    write_element_count(11'd0);
    send_item(FUNC_QUERY, 10'd0, 11'd1, '0);
    drain_results();
    write_element_count(11'd1);
    send_item(FUNC_ASSIGN, 10'd0, 11'd1, 32'd7);
    send_item(FUNC_QUERY, 10'd0, 11'd2, '0);
    send_item(FUNC_QUERY, 10'd0, 11'd1, '0);
    drain_results();
    write_element_count(11'd2047);
    send_item(FUNC_QUERY, 10'd0, 11'd1025, '0);
    send_item(FUNC_QUERY, 10'd0, 11'd1024, '0);
    drain_results();
  endtask

  task automatic test_random(int items, logic [10:0] cnt, int span);
    write_element_count(cnt);
    for (int i = 0; i < items; i++) random_item(span);
    drain_results();
  endtask

  initial begin
    foreach (elem_value[i]) elem_value[i] = '0;
    active_count = ELEMENT_COUNT_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_wraparound();
    test_count_limits();
    test_random(300, 11'd1024, 1024);
    test_random(200, 11'd37, 40);
    test_random(150, 11'd1024, 16);
    test_random(150, 11'd700, 1024);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
